// ----- design/pke_pkg.sv -----
// ----------------------------------------------------------------------------
// pke_pkg
// Types and constants shared by the partition entry encoder pipeline.
// ----------------------------------------------------------------------------
package pke_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_CYL_COUNT  = 2'd0;
    localparam logic [1:0] CFG_HEAD_COUNT = 2'd1;
    localparam logic [1:0] CFG_SECT_COUNT = 2'd2;

    localparam logic [15:0] CYL_RESET  = 16'd306;
    localparam logic [8:0]  HEAD_RESET = 9'd4;
    localparam logic [5:0]  SECT_RESET = 6'd17;

    // highest cylinder that the chs fields can hold
    localparam logic [15:0] CYL_LIMIT     = 16'd1023;
    localparam logic [7:0]  HIGH_CYL_BITS = 8'hC0;
    localparam logic [7:0]  BYTE_MASK     = 8'hFF;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ORDER      = 2'd1,
        ST_FIRST_HIGH = 2'd2,
        ST_LAST_HIGH  = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] cylinder_count;
        logic [8:0]  head_count;
        logic [5:0]  sector_count;
    } t_geom;

    typedef struct packed {
        logic [1:0]  slot;
        logic [7:0]  system_id;
        logic [15:0] first_cyl;
        logic [15:0] last_cyl;
    } t_req;

    typedef struct packed {
        logic [1:0]  slot_out;
        t_status     status;
        logic        active_byte;
        logic [7:0]  begin_head;
        logic [7:0]  begin_sector_byte;
        logic [7:0]  begin_cyl_byte;
        logic [7:0]  type_byte;
        logic [7:0]  end_head;
        logic [7:0]  end_sector_byte;
        logic [7:0]  end_cyl_byte;
        logic [31:0] start_lba;
        logic [31:0] length_sectors;
    } t_rsp;

    // after the check and head multiply
    typedef struct packed {
        logic [1:0]  slot;
        logic [7:0]  system_id;
        t_status     status;
        logic        kill;
        logic        bh;
        logic [9:0]  first_lo;
        logic [9:0]  ec;
        logic [8:0]  eh;
        logic [24:0] first_h;
        logic [24:0] last_h;
    } t_s1;

    // after the sector multiply
    typedef struct packed {
        logic [1:0]  slot;
        logic [7:0]  system_id;
        t_status     status;
        logic        kill;
        logic        bh;
        logic [9:0]  first_lo;
        logic [9:0]  ec;
        logic [7:0]  eh_lo;
        logic [31:0] beg;
        logic [31:0] end_lba;
    } t_s2;

endpackage

// ----- design/pke_check_stage.sv -----
// ----------------------------------------------------------------------------
// pke_check_stage
// Range checks against the geometry and cylinder times head count.
// ----------------------------------------------------------------------------
module pke_check_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pke_pkg::t_geom i_geom,
    input  logic           i_valid,
    input  pke_pkg::t_req  i_req,
    output logic           o_ready,
    input  logic           i_ready,
    output logic           o_valid,
    output pke_pkg::t_s1   o_data
);

    logic         r_valid;
    pke_pkg::t_s1 r_data;
    pke_pkg::t_s1 n_data;
    logic [15:0]  ec_full;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        ec_full = (i_req.last_cyl > pke_pkg::CYL_LIMIT) ? pke_pkg::CYL_LIMIT : i_req.last_cyl;
        n_data.slot      = i_req.slot;
        n_data.system_id = i_req.system_id;
        priority if (i_req.first_cyl > i_req.last_cyl) begin
            n_data.status = pke_pkg::ST_ORDER;
        end else if (i_req.first_cyl > pke_pkg::CYL_LIMIT) begin
            n_data.status = pke_pkg::ST_FIRST_HIGH;
        end else if (i_req.last_cyl >= i_geom.cylinder_count) begin
            n_data.status = pke_pkg::ST_LAST_HIGH;
        end else begin
            n_data.status = pke_pkg::ST_OK;
        end
        // a zero id clears the entry and skips the checks
        if (i_req.system_id == 8'd0) begin
            n_data.status = pke_pkg::ST_OK;
        end
        n_data.kill     = (i_req.system_id == 8'd0) || (n_data.status != pke_pkg::ST_OK);
        n_data.bh       = (i_req.first_cyl == 16'd0);
        n_data.first_lo = i_req.first_cyl[9:0];
        n_data.ec       = ec_full[9:0];
        n_data.eh       = i_geom.head_count - 9'd1;
        n_data.first_h  = 25'(i_req.first_cyl) * 25'(i_geom.head_count);
        n_data.last_h   = 25'(i_req.last_cyl) * 25'(i_geom.head_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- design/pke_scale_stage.sv -----
// ----------------------------------------------------------------------------
// pke_scale_stage
// Adds the head offsets and scales both points by sectors per track.
// ----------------------------------------------------------------------------
module pke_scale_stage (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [5:0]   i_sectors,
    input  logic         i_valid,
    input  pke_pkg::t_s1 i_data,
    output logic         o_ready,
    input  logic         i_ready,
    output logic         o_valid,
    output pke_pkg::t_s2 o_data
);

    logic         r_valid;
    pke_pkg::t_s2 r_data;
    pke_pkg::t_s2 n_data;
    logic [25:0]  beg_track;
    logic [25:0]  end_track;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        beg_track = 26'(i_data.first_h) + 26'(i_data.bh);
        end_track = 26'(i_data.last_h) + 26'(i_data.eh);
        n_data.slot      = i_data.slot;
        n_data.system_id = i_data.system_id;
        n_data.status    = i_data.status;
        n_data.kill      = i_data.kill;
        n_data.bh        = i_data.bh;
        n_data.first_lo  = i_data.first_lo;
        n_data.ec        = i_data.ec;
        n_data.eh_lo     = i_data.eh[7:0];
        n_data.beg       = 32'(beg_track) * 32'(i_sectors);
        n_data.end_lba   = 32'(end_track) * 32'(i_sectors);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- design/pke_out_stage.sv -----
// ----------------------------------------------------------------------------
// pke_out_stage
// Length subtract and packing of the entry bytes into the output register.
// ----------------------------------------------------------------------------
module pke_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [5:0]    i_sectors,
    input  logic          i_valid,
    input  pke_pkg::t_s2  i_data,
    output logic          o_ready,
    input  logic          i_ready,
    output logic          o_valid,
    output pke_pkg::t_rsp o_data
);

    logic          r_valid;
    pke_pkg::t_rsp r_data;
    pke_pkg::t_rsp n_data;
    logic [5:0]    end_sector;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        // a zero sector count still counts the end sector as one
        end_sector = (i_sectors == 6'd0) ? 6'd1 : i_sectors;
        n_data = '0;
        n_data.slot_out = i_data.slot;
        n_data.status   = i_data.status;
        if (!i_data.kill) begin
            n_data.begin_head        = {7'd0, i_data.bh};
            n_data.begin_sector_byte = (8'(i_data.first_lo >> 2) & pke_pkg::HIGH_CYL_BITS)
                                       | 8'h01;
            n_data.begin_cyl_byte    = i_data.first_lo[7:0] & pke_pkg::BYTE_MASK;
            n_data.type_byte         = i_data.system_id;
            n_data.end_head          = i_data.eh_lo;
            n_data.end_sector_byte   = (8'(i_data.ec >> 2) & pke_pkg::HIGH_CYL_BITS)
                                       | {2'b00, i_sectors};
            n_data.end_cyl_byte      = i_data.ec[7:0] & pke_pkg::BYTE_MASK;
            n_data.start_lba         = i_data.beg;
            n_data.length_sectors    = i_data.end_lba + 32'(end_sector) - i_data.beg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- design/partition_entry_encoder_top.sv -----
// ----------------------------------------------------------------------------
// partition_entry_encoder_top
// Throughput: one request per cycle while the result side does not stall;
// the check, sector multiply and packing stages set the depth.
// Reset clears the stage valid bits and loads the geometry 306/4/17.
// ----------------------------------------------------------------------------
module partition_entry_encoder_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_valid,
    input  pke_pkg::t_req i_req,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output pke_pkg::t_rsp o_rsp
);

    pke_pkg::t_geom r_geom;
    logic           s1_ready;
    logic           s1_valid;
    pke_pkg::t_s1   s1_data;
    logic           s2_ready;
    logic           s2_valid;
    pke_pkg::t_s2   s2_data;
    logic           s3_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.cylinder_count <= pke_pkg::CYL_RESET;
            r_geom.head_count     <= pke_pkg::HEAD_RESET;
            r_geom.sector_count   <= pke_pkg::SECT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pke_pkg::CFG_CYL_COUNT:  r_geom.cylinder_count <= i_cfg_data;
                pke_pkg::CFG_HEAD_COUNT: r_geom.head_count     <= i_cfg_data[8:0];
                pke_pkg::CFG_SECT_COUNT: r_geom.sector_count   <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign o_stall = !s1_ready;

    pke_check_stage u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (r_geom),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_ready (s1_ready),
        .i_ready (s2_ready),
        .o_valid (s1_valid),
        .o_data  (s1_data)
    );

    pke_scale_stage u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sectors (r_geom.sector_count),
        .i_valid   (s1_valid),
        .i_data    (s1_data),
        .o_ready   (s2_ready),
        .i_ready   (s3_ready),
        .o_valid   (s2_valid),
        .o_data    (s2_data)
    );

    pke_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sectors (r_geom.sector_count),
        .i_valid   (s2_valid),
        .i_data    (s2_data),
        .o_ready   (s3_ready),
        .i_ready   (!i_stall),
        .o_valid   (o_valid),
        .o_data    (o_rsp)
    );

    // input side only backs up once every stage holds an item
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (s1_valid && s2_valid && o_valid))
        else $error("input stalled with a free pipeline stage");

    a_error_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != pke_pkg::ST_OK)
        |-> (o_rsp.start_lba == 32'd0 && o_rsp.type_byte == 8'd0))
        else $error("range error result carries entry fields");

    a_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.type_byte == 8'd0)
        |-> (o_rsp.length_sectors == 32'd0 && o_rsp.begin_head == 8'd0))
        else $error("cleared entry carries geometry fields");

    a_begin_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.type_byte != 8'd0) |-> (o_rsp.begin_sector_byte[5:0] == 6'd1))
        else $error("begin sector is not one");

endmodule

// ----- dv/pke_entry_checker.sv -----
// ----------------------------------------------------------------------------
// pke_entry_checker
// Watches the request, result and register ports of the partition entry
// encoder, predicts each partition entry and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pke_entry_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_req_valid,
    input  logic           i_req_stall,
    input  pke_pkg::t_req  i_req,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_stall,
    input  pke_pkg::t_rsp  i_rsp,
    output int             o_mismatches,
    output int             o_pending
);

    pke_pkg::t_geom geom;
    pke_pkg::t_rsp  entry_q[$];
    int             mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic report_mismatch(input string msg);
        $display("%0t entry check: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
        end
    endtask

    function automatic pke_pkg::t_rsp encode_entry(input pke_pkg::t_req r,
                                                   input pke_pkg::t_geom g);
        pke_pkg::t_rsp e;
        logic          begin_hd;
        logic [8:0]    last_head;
        logic [15:0]   end_cyl;
        logic [15:0]   first_sh;
        logic [15:0]   end_sh;
        logic [63:0]   first_w;
        logic [63:0]   last_w;
        logic [63:0]   heads_w;
        logic [63:0]   sects_w;
        logic [63:0]   end_off;
        logic [63:0]   begin_lba;
        logic [63:0]   end_lba;
        logic [63:0]   span;
        e = '0;
        e.slot_out = r.slot;
        // a zero id clears the entry without any range check
        if (r.system_id == 8'd0) begin
            return e;
        end
        if (r.first_cyl > r.last_cyl) begin
            e.status = pke_pkg::ST_ORDER;
        end else if (r.first_cyl > pke_pkg::CYL_LIMIT) begin
            e.status = pke_pkg::ST_FIRST_HIGH;
        end else if (r.last_cyl >= g.cylinder_count) begin
            e.status = pke_pkg::ST_LAST_HIGH;
        end else begin
            e.status = pke_pkg::ST_OK;
        end
        if (e.status != pke_pkg::ST_OK) begin
            return e;
        end

        begin_hd  = (r.first_cyl == 16'd0);
        last_head = g.head_count - 9'd1;
        end_cyl   = (r.last_cyl > pke_pkg::CYL_LIMIT) ? pke_pkg::CYL_LIMIT : r.last_cyl;
        first_w   = {48'd0, r.first_cyl};
        last_w    = {48'd0, r.last_cyl};
        heads_w   = {55'd0, g.head_count};
        sects_w   = {58'd0, g.sector_count};
        // zero sectors per track still counts the end sector as the first one
        end_off   = (g.sector_count == 6'd0) ? 64'd0 : sects_w - 64'd1;
        begin_lba = (first_w * heads_w + {63'd0, begin_hd}) * sects_w;
        end_lba   = (last_w * heads_w + {55'd0, last_head}) * sects_w + end_off;
        span      = end_lba + 64'd1 - begin_lba;
        first_sh  = r.first_cyl >> 2;
        end_sh    = end_cyl >> 2;

        e.active_byte       = 1'b0;
        e.begin_head        = {7'd0, begin_hd};
        e.begin_sector_byte = 8'h01 | (first_sh[7:0] & pke_pkg::HIGH_CYL_BITS);
        e.begin_cyl_byte    = r.first_cyl[7:0] & pke_pkg::BYTE_MASK;
        e.type_byte         = r.system_id;
        e.end_head          = last_head[7:0];
        e.end_sector_byte   = {2'b00, g.sector_count} | (end_sh[7:0] & pke_pkg::HIGH_CYL_BITS);
        e.end_cyl_byte      = end_cyl[7:0] & pke_pkg::BYTE_MASK;
        e.start_lba         = begin_lba[31:0];
        e.length_sectors    = span[31:0];
        return e;
    endfunction

    task automatic compare_entry(input pke_pkg::t_rsp want, input pke_pkg::t_rsp got);
        check_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("active_byte", 32'(want.active_byte), 32'(got.active_byte));
        check_field("begin_head", 32'(want.begin_head), 32'(got.begin_head));
        check_field("begin_sector_byte", 32'(want.begin_sector_byte),
                    32'(got.begin_sector_byte));
        check_field("begin_cyl_byte", 32'(want.begin_cyl_byte), 32'(got.begin_cyl_byte));
        check_field("type_byte", 32'(want.type_byte), 32'(got.type_byte));
        check_field("end_head", 32'(want.end_head), 32'(got.end_head));
        check_field("end_sector_byte", 32'(want.end_sector_byte), 32'(got.end_sector_byte));
        check_field("end_cyl_byte", 32'(want.end_cyl_byte), 32'(got.end_cyl_byte));
        check_field("start_lba", want.start_lba, got.start_lba);
        check_field("length_sectors", want.length_sectors, got.length_sectors);
    endtask

    always @(posedge i_clk) begin : monitor
        pke_pkg::t_rsp want;
        if (!i_rst_n) begin
            geom.cylinder_count <= pke_pkg::CYL_RESET;
            geom.head_count     <= pke_pkg::HEAD_RESET;
            geom.sector_count   <= pke_pkg::SECT_RESET;
            entry_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pke_pkg::CFG_CYL_COUNT: begin
                        geom.cylinder_count <= i_cfg_data;
                    end
                    pke_pkg::CFG_HEAD_COUNT: begin
                        geom.head_count <= i_cfg_data[8:0];
                    end
                    pke_pkg::CFG_SECT_COUNT: begin
                        geom.sector_count <= i_cfg_data[5:0];
                    end
                    default: begin
                    end
                endcase
            end
            // result side first so a same-edge request never matches itself
            if (i_rsp_valid && !i_rsp_stall) begin
                if (entry_q.size() == 0) begin
                    report_mismatch("result transfer with no request outstanding");
                end else begin
                    want = entry_q.pop_front();
                    compare_entry(want, i_rsp);
                end
            end
            if (i_req_valid && !i_req_stall) begin
                entry_q.push_back(encode_entry(i_req, geom));
            end
            o_pending <= entry_q.size();
        end
    end

endmodule

// ----- dv/partition_entry_encoder_top_tb.sv -----
// ----------------------------------------------------------------------------
// partition_entry_encoder_top_tb
// Drives directed and random partition requests over several disk geometries,
// with random gaps and back-pressure; the entry checker judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module partition_entry_encoder_top_tb;

    localparam logic [1:0] CFG_SPARE  = 2'd3;
    localparam int         IDLE_LIMIT = 500;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [15:0]   i_cfg_data;
    logic          i_valid;
    pke_pkg::t_req i_req;
    logic          o_stall;
    logic          o_valid;
    logic          i_stall;
    pke_pkg::t_rsp o_rsp;

    int   mismatches;
    int   pending;
    int   idle_cycles = 0;
    int   cur_cyl;
    logic steady = 1'b0;

    partition_entry_encoder_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_req      (i_req),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp)
    );

    pke_entry_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req        (i_req),
        .i_rsp_valid  (o_valid),
        .i_rsp_stall  (i_stall),
        .i_rsp        (o_rsp),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    // result side back-pressure
    initial begin : rsp_stall
        int n;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            n = steady ? 0 : $urandom_range(0, 5);
            if (n != 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // timeout when nothing transfers for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_entry(input pke_pkg::t_req r);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_req(input logic [1:0] slot, input logic [7:0] id,
                            input logic [15:0] first, input logic [15:0] last);
        pke_pkg::t_req r;
        r.slot      = slot;
        r.system_id = id;
        r.first_cyl = first;
        r.last_cyl  = last;
        send_entry(r);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // caller must have drained the pipe; spare index gets junk that must be ignored
    task automatic set_geometry(input logic [15:0] cyl, input logic [8:0] heads,
                                input logic [5:0] sects);
        logic [15:0] noise;
        cur_cyl = int'(cyl);
        noise = 16'($urandom_range(0, 65535));
        write_reg(CFG_SPARE, noise);
        write_reg(pke_pkg::CFG_CYL_COUNT, cyl);
        noise = 16'($urandom_range(0, 65535));
        write_reg(pke_pkg::CFG_HEAD_COUNT, {noise[15:9], heads});
        noise = 16'($urandom_range(0, 65535));
        write_reg(pke_pkg::CFG_SECT_COUNT, {noise[15:6], sects});
        i_cfg_we <= 1'b0;
    endtask

    function automatic pke_pkg::t_req random_request();
        pke_pkg::t_req r;
        int unsigned   pick;
        int            top_first;
        int            lo;
        r.slot      = 2'($urandom_range(0, 3));
        r.system_id = 8'($urandom_range(1, 255));
        r.first_cyl = 16'($urandom_range(0, 65535));
        r.last_cyl  = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            // well-formed entry inside the current geometry
            if (cur_cyl != 0) begin
                top_first = (cur_cyl - 1 < 1023) ? cur_cyl - 1 : 1023;
                r.first_cyl = ($urandom_range(0, 7) == 0) ? 16'd0
                                                          : 16'($urandom_range(0, top_first));
                r.last_cyl  = 16'($urandom_range(r.first_cyl, cur_cyl - 1));
            end
        end else if (pick < 78) begin
            r.system_id = 8'd0;
        end else if (pick < 85 && r.last_cyl != 16'hFFFF) begin
            r.first_cyl = 16'($urandom_range(r.last_cyl + 1, 65535));
        end else if (pick < 92) begin
            r.first_cyl = 16'($urandom_range(1024, 65535));
            r.last_cyl  = 16'($urandom_range(r.first_cyl, 65535));
        end else if (pick < 97) begin
            r.first_cyl = 16'($urandom_range(0, 1023));
            lo = (int'(r.first_cyl) > cur_cyl) ? int'(r.first_cyl) : cur_cyl;
            r.last_cyl  = 16'($urandom_range(lo, 65535));
        end
        return r;
    endfunction

    task automatic run_random(input int count);
        for (int k = 0; k < count; k++) begin
            steady = ((k % 60) >= 45);
            if (k == count / 2) begin
                wait_drained();
            end
            send_entry(random_request());
        end
        steady = 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] cyl, input logic [8:0] heads,
                             input logic [5:0] sects);
        wait_drained();
        set_geometry(cyl, heads, sects);
        if (cyl != 16'd0) begin
            send_req(2'd0, 8'h0C, 16'd0, cyl - 16'd1);
            send_req(2'd3, 8'hA5, (cyl > 16'd1023) ? 16'd1023 : cyl - 16'd1, cyl - 16'd1);
        end
        run_random(48);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= pke_pkg::CFG_CYL_COUNT;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_req      <= '0;
        cur_cyl     = int'(pke_pkg::CYL_RESET);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry 306/4/17
        send_req(2'd0, 8'h00, 16'hFFFF, 16'hFFFF);
        send_req(2'd3, 8'hFF, 16'd0, 16'd0);
        send_req(2'd1, 8'h83, 16'd1, 16'd305);
        send_req(2'd2, 8'h05, 16'd0, 16'd305);
        send_req(2'd0, 8'h07, 16'd5, 16'd4);
        send_req(2'd1, 8'h0C, 16'hFFFF, 16'd0);
        send_req(2'd2, 8'h0B, 16'd1024, 16'hFFFF);
        send_req(2'd3, 8'h06, 16'hFFFF, 16'hFFFF);
        send_req(2'd0, 8'h01, 16'd0, 16'd306);
        send_req(2'd1, 8'h01, 16'd300, 16'hFFFF);
        send_req(2'd2, 8'h01, 16'd305, 16'd305);
        run_random(40);

        // largest cylinder count: clamping of the end cylinder and its high bits
        wait_drained();
        set_geometry(16'hFFFF, 9'd256, 6'd63);
        send_req(2'd0, 8'h83, 16'd1023, 16'd65534);
        send_req(2'd1, 8'h82, 16'd0, 16'd1023);
        send_req(2'd2, 8'h0E, 16'd768, 16'd1024);
        send_req(2'd3, 8'h0F, 16'd1023, 16'd1023);
        send_req(2'd0, 8'h01, 16'd1024, 16'd1024);
        send_req(2'd1, 8'h01, 16'd0, 16'hFFFF);
        run_random(55);

        run_phase(16'd0, 9'd0, 6'd0);
        run_phase(16'd1, 9'd1, 6'd1);
        run_phase(16'hFFFF, 9'd0, 6'd0);
        run_phase(16'd2000, 9'd511, 6'd63);
        run_phase(16'd1024, 9'd257, 6'd32);
        repeat (4) begin
            run_phase(16'($urandom_range(1, 65535)), 9'($urandom_range(1, 256)),
                      6'($urandom_range(1, 63)));
        end

        wait_drained();
        repeat (6) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/pke_pkg.sv
design/pke_check_stage.sv
design/pke_scale_stage.sv
design/pke_out_stage.sv
design/partition_entry_encoder_top.sv
dv/pke_entry_checker.sv
dv/partition_entry_encoder_top_tb.sv
